[src/vcrf_pkg.sv]
// vcrf_pkg: types, register offsets and reset values shared by the
// video chip register file modules
// no dependencies
package vcrf_pkg;

  localparam int unsigned WinSize = 64;
  localparam int unsigned WinAw   = $clog2(WinSize);

  typedef logic [WinAw-1:0] off_t;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_CHAR      = 3'd0,
    MODE_MC_CHAR   = 3'd1,
    MODE_BITMAP    = 3'd2,
    MODE_MC_BITMAP = 3'd3,
    MODE_EXT_BG    = 3'd4,
    MODE_ILLEGAL   = 3'd5
  } mode_e;

  localparam off_t OFF_SPR_MSB   = 6'h10;
  localparam off_t OFF_CTRL1     = 6'h11;
  localparam off_t OFF_RASTER    = 6'h12;
  localparam off_t OFF_PEN_X     = 6'h13;
  localparam off_t OFF_PEN_Y     = 6'h14;
  localparam off_t OFF_SPR_EN    = 6'h15;
  localparam off_t OFF_CTRL2     = 6'h16;
  localparam off_t OFF_SPR_YEXP  = 6'h17;
  localparam off_t OFF_MEM_PTR   = 6'h18;
  localparam off_t OFF_IRQ_FLAG  = 6'h19;
  localparam off_t OFF_IRQ_MASK  = 6'h1a;
  localparam off_t OFF_SPR_PRIO  = 6'h1b;
  localparam off_t OFF_SPR_MC    = 6'h1c;
  localparam off_t OFF_SPR_XEXP  = 6'h1d;
  localparam off_t OFF_SS_COLL   = 6'h1e;
  localparam off_t OFF_SD_COLL   = 6'h1f;
  localparam off_t OFF_COLOR_LO  = 6'h20;
  localparam off_t OFF_COLOR_HI  = 6'h2e;

  localparam logic [7:0] RST_CTRL    = 8'h08;
  localparam logic [7:0] RST_MEM_PTR = 8'h14;
  localparam logic [7:0] UNCONNECTED = 8'hff;

  // one accepted beat as seen by the register and latch logic
  typedef struct packed {
    logic       accept;
    cmd_e       cmd;
    off_t       off;
    logic [7:0] wdata;
    logic [7:0] ss_hits;
    logic [7:0] sd_hits;
  } acc_t;

  typedef struct packed {
    logic [7:0] ctrl1;
    logic [7:0] ctrl2;
    logic [7:0] mem_ptr;
    logic [7:0] irq_mask;
    logic [8:0] raster_cmp;
    mode_e      mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ss;
    logic [7:0] sd;
  } coll_t;

  function automatic logic [7:0] reset_byte(off_t off);
    logic [7:0] val;
    val = '0;
    if (off == OFF_CTRL1 || off == OFF_CTRL2) val = RST_CTRL;
    if (off == OFF_MEM_PTR) val = RST_MEM_PTR;
    return val;
  endfunction

  function automatic mode_e decode_mode(logic [7:0] ctrl1, logic [7:0] ctrl2);
    logic [2:0] key;
    key = {ctrl1[6], ctrl1[5], ctrl2[4]};
    return (key <= 3'd4) ? mode_e'(key) : MODE_ILLEGAL;
  endfunction

endpackage

[src/vcrf_regmem.sv]
// vcrf_regmem: 64 x 8 register window storage with registered read
// and per-entry written flags; depends on vcrf_pkg
module vcrf_regmem (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vcrf_pkg::acc_t acc_i,
  output logic [7:0]    rd_data_o,
  output logic          rd_hit_o
);
  import vcrf_pkg::*;

  logic [7:0]         mem_q [WinSize];
  logic [WinSize-1:0] written_q;
  logic [7:0]         rd_data_q;
  logic               rd_hit_q;
  logic               wr_en;

  assign wr_en = acc_i.accept && (acc_i.cmd == CMD_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[acc_i.off] <= acc_i.wdata;
    end
    if (acc_i.accept) begin
      rd_data_q <= mem_q[acc_i.off];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        written_q[acc_i.off] <= 1'b1;
      end
      if (acc_i.accept) begin
        rd_hit_q <= written_q[acc_i.off];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_hit_o  = rd_hit_q;

endmodule

[src/vcrf_state.sv]
// vcrf_state: decoded control registers, raster compare, display mode
// and clear-on-read collision latches; depends on vcrf_pkg
module vcrf_state (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vcrf_pkg::acc_t  acc_i,
  output vcrf_pkg::cfg_t  cfg_o,
  output vcrf_pkg::coll_t coll_o
);
  import vcrf_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [7:0] ss_q, ss_d;
  logic [7:0] sd_q, sd_d;
  logic       wr, rd;

  assign wr = acc_i.accept && (acc_i.cmd == CMD_WRITE);
  assign rd = acc_i.accept && (acc_i.cmd == CMD_READ);

  assign coll_o.ss = ss_q | acc_i.ss_hits;
  assign coll_o.sd = sd_q | acc_i.sd_hits;

  always_comb begin
    cfg_d = cfg_q;
    ss_d  = ss_q;
    sd_d  = sd_q;
    if (acc_i.accept) begin
      ss_d = (rd && acc_i.off == OFF_SS_COLL) ? 8'h00 : coll_o.ss;
      sd_d = (rd && acc_i.off == OFF_SD_COLL) ? 8'h00 : coll_o.sd;
    end
    if (wr) begin
      if (acc_i.off == OFF_CTRL1) begin
        cfg_d.ctrl1         = acc_i.wdata;
        cfg_d.raster_cmp[8] = acc_i.wdata[7];
      end
      if (acc_i.off == OFF_RASTER) cfg_d.raster_cmp[7:0] = acc_i.wdata;
      if (acc_i.off == OFF_CTRL2) cfg_d.ctrl2 = acc_i.wdata;
      if (acc_i.off == OFF_MEM_PTR) cfg_d.mem_ptr = acc_i.wdata;
      if (acc_i.off == OFF_IRQ_MASK) cfg_d.irq_mask = acc_i.wdata;
      if (acc_i.off == OFF_CTRL1 || acc_i.off == OFF_CTRL2) begin
        cfg_d.mode = decode_mode(cfg_d.ctrl1, cfg_d.ctrl2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ctrl1      <= RST_CTRL;
      cfg_q.ctrl2      <= RST_CTRL;
      cfg_q.mem_ptr    <= RST_MEM_PTR;
      cfg_q.irq_mask   <= '0;
      cfg_q.raster_cmp <= '0;
      cfg_q.mode       <= MODE_CHAR;
      ss_q             <= '0;
      sd_q             <= '0;
    end else begin
      cfg_q <= cfg_d;
      ss_q  <= ss_d;
      sd_q  <= sd_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/video_chip_register_file.sv]
// video_chip_register_file: top level, access stage, read data composition
// and output register; depends on vcrf_pkg, vcrf_regmem, vcrf_state
//
// One beat per cycle in each direction when not stalled; beats pass the access
// stage, then the output register. A beat is accepted while the access stage
// is empty or moving on; at that edge the window storage is written or read,
// control registers and the collision latches update and live status bytes
// are captured. The access stage composes the read byte from the registered
// storage read and moves it, with a snapshot of the decoded control outputs,
// into the output register. The window repeats every 64 bytes of the offset.
// Rate is set by the single storage port, used once per beat.
module video_chip_register_file (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vcrf_pkg::cmd_e cmd_i,
  input  logic [9:0]    addr_i,
  input  logic [7:0]    wdata_i,
  input  logic [8:0]    raster_line_i,
  input  logic [7:0]    pen_x_i,
  input  logic [7:0]    pen_y_i,
  input  logic [7:0]    sprite_sprite_hits_i,
  input  logic [7:0]    sprite_data_hits_i,
  input  logic [3:0]    irq_event_flags_i,
  input  logic          irq_pending_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    rdata_o,
  output logic [2:0]    graphic_mode_o,
  output logic [8:0]    raster_compare_o,
  output logic [3:0]    irq_enable_o,
  output logic [13:0]   char_base_o,
  output logic [13:0]   screen_base_o,
  output logic [13:0]   bitmap_base_o,
  output logic [2:0]    scroll_x_o,
  output logic [2:0]    scroll_y_o,
  output logic [3:0]    control_flags_o
);
  import vcrf_pkg::*;

  acc_t       acc;
  cfg_t       cfg;
  coll_t      coll;
  logic [7:0] mem_rd;
  logic       mem_hit;

  logic       a_valid_q;
  logic       a_read_q;
  off_t       a_off_q;
  logic [7:0] a_live_q;
  logic       a_move;
  logic [7:0] live_d;
  logic [7:0] stored;
  logic [7:0] rdata_d;

  logic       out_valid_q;
  logic [7:0] rdata_q;
  mode_e      mode_q;
  logic [8:0] rcmp_q;
  logic [3:0] ien_q;
  logic [7:0] mem_ptr_q;
  logic [2:0] scroll_x_q;
  logic [2:0] scroll_y_q;
  logic [3:0] flags_q;

  assign a_move     = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || a_move;

  assign acc.accept  = in_valid_i && in_ready_o;
  assign acc.cmd     = cmd_i;
  assign acc.off     = addr_i[WinAw-1:0];
  assign acc.wdata   = wdata_i;
  assign acc.ss_hits = sprite_sprite_hits_i;
  assign acc.sd_hits = sprite_data_hits_i;

  vcrf_regmem u_regmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .rd_data_o (mem_rd),
    .rd_hit_o  (mem_hit)
  );

  vcrf_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .cfg_o  (cfg),
    .coll_o (coll)
  );

  // live status bytes, taken at accept
  always_comb begin
    unique case (acc.off)
      OFF_CTRL1:    live_d = {raster_line_i[8], 7'b0};
      OFF_RASTER:   live_d = raster_line_i[7:0];
      OFF_PEN_X:    live_d = pen_x_i;
      OFF_PEN_Y:    live_d = pen_y_i;
      OFF_IRQ_FLAG: live_d = {irq_pending_i, 3'b111, irq_event_flags_i};
      OFF_SS_COLL:  live_d = coll.ss;
      OFF_SD_COLL:  live_d = coll.sd;
      default:      live_d = UNCONNECTED;
    endcase
  end

  assign stored = mem_hit ? mem_rd : reset_byte(a_off_q);

  always_comb begin
    rdata_d = UNCONNECTED;
    if (!a_read_q) begin
      rdata_d = 8'h00;
    end else if (a_off_q <= OFF_SPR_MSB) begin
      rdata_d = stored;
    end else begin
      unique case (a_off_q)
        OFF_CTRL1:    rdata_d = {a_live_q[7], stored[6:0]};
        OFF_CTRL2:    rdata_d = {2'b11, stored[5:0]};
        OFF_IRQ_MASK: rdata_d = {4'hf, stored[3:0]};
        OFF_SPR_EN, OFF_SPR_YEXP, OFF_MEM_PTR, OFF_SPR_PRIO, OFF_SPR_MC,
        OFF_SPR_XEXP: rdata_d = stored;
        OFF_RASTER, OFF_PEN_X, OFF_PEN_Y, OFF_IRQ_FLAG, OFF_SS_COLL,
        OFF_SD_COLL:  rdata_d = a_live_q;
        default: begin
          if (a_off_q >= OFF_COLOR_LO && a_off_q <= OFF_COLOR_HI) begin
            rdata_d = {4'hf, stored[3:0]};
          end else begin
            rdata_d = UNCONNECTED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) a_valid_q <= in_valid_i;
      if (a_move) out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc.accept) begin
      a_read_q <= (cmd_i == CMD_READ);
      a_off_q  <= acc.off;
      a_live_q <= live_d;
    end
    if (a_move && a_valid_q) begin
      rdata_q    <= rdata_d;
      mode_q     <= cfg.mode;
      rcmp_q     <= cfg.raster_cmp;
      ien_q      <= cfg.irq_mask[3:0];
      mem_ptr_q  <= cfg.mem_ptr;
      scroll_x_q <= cfg.ctrl2[2:0];
      scroll_y_q <= cfg.ctrl1[2:0];
      flags_q    <= {cfg.ctrl2[5], cfg.ctrl1[4], cfg.ctrl2[3], cfg.ctrl1[3]};
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rdata_o          = rdata_q;
  assign graphic_mode_o   = mode_q;
  assign raster_compare_o = rcmp_q;
  assign irq_enable_o     = ien_q;
  assign char_base_o      = {mem_ptr_q[3:1], 11'b0};
  assign screen_base_o    = {mem_ptr_q[7:4], 10'b0};
  assign bitmap_base_o    = {mem_ptr_q[3], 13'b0};
  assign scroll_x_o       = scroll_x_q;
  assign scroll_y_o       = scroll_y_q;
  assign control_flags_o  = flags_q;

`ifndef ASSERT_OFF
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_move |=> a_valid_q && $stable(a_off_q) && $stable(a_live_q))
    else $error("access stage lost a stalled beat");

  ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  raster_msb_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc.accept && cmd_i == CMD_WRITE && acc.off == OFF_CTRL1
    |=> cfg.raster_cmp[8] == $past(wdata_i[7]))
    else $error("raster compare bit 8 not taken from control write");
`endif

endmodule
